[design/wpdm_pkg.sv]
// Shared constants, types and control structs for the windowed PWM duty meter.
package wpdm_pkg;

   localparam int CHANNELS    = 6;
   localparam int COUNT_BITS  = 16;
   localparam int ACC_BITS    = 24;
   localparam int DUTY_BITS   = 16;
   localparam int FRAC_BITS   = 15;
   localparam int TICKS_BITS  = 16;
   localparam int WINDOW_BITS = 8;
   localparam int ENABLE_BITS = 6;
   localparam int DIV_BITS    = TICKS_BITS + WINDOW_BITS;
   localparam int CH_BITS     = $clog2(CHANNELS);
   localparam int STEP_BITS   = $clog2(FRAC_BITS + 1);
   localparam int ENTRY_BITS  = COUNT_BITS + ACC_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [DUTY_BITS-1:0]   DUTY_ONE         = DUTY_BITS'(1) << FRAC_BITS;
   localparam logic [TICKS_BITS-1:0]  TICKS_RESET      = 16'd18750;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET     = 8'd100;
   localparam logic [ENABLE_BITS-1:0] ENABLE_RESET     = 6'd63;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TICKS_PER_SAMPLE   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLES_PER_WINDOW = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNEL_ENABLE     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_DIVIDE,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic                start;
      logic [ACC_BITS-1:0] dividend;
      logic [DIV_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DUTY_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

[design/windowed_pwm_duty_meter.sv]
// Top level of the six-channel windowed PWM duty meter.
//
//  channel | direction | payload (lowest bits first)            | handshake
//  req_    | in        | count_ch0 .. count_ch5, 16 bit each     | tvalid/tready
//  rsp_    | out       | duty_ch0 .. duty_ch5, Q1.15, 16 bit     | tvalid/tready
//  csr_    | in        | index 0 ticks, 1 window, 2 enable       | write enable
//
// Sequence: a request is accepted, then each channel in turn is read from
//   memory and written back. At window end each enabled channel also runs
//   the serial divider (15 quotient bits), which skips the bit steps when
//   the result clamps or the divisor is zero, and the window is then published.
// Reset: synchronous; the per-channel state memory is qualified by valid bits
//   that reset clears, so no clearing pass is needed.
// Stalls: a finished result waits in the output register; work continues on
//   later requests until a new window must be published over an unread one.
module windowed_pwm_duty_meter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // count_ch0 [15:0], count_ch1, ... count_ch5 [95:80]
   input  logic [wpdm_pkg::CHANNELS*wpdm_pkg::COUNT_BITS-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // duty_ch0 [15:0], duty_ch1, ... duty_ch5 [95:80]
   output logic [wpdm_pkg::CHANNELS*wpdm_pkg::DUTY_BITS-1:0]  rsp_tdata,
   input  logic                                 csr_we,
   input  logic [wpdm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [wpdm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   // configuration
   logic [wpdm_pkg::TICKS_BITS-1:0]  ticks_ff;
   logic [wpdm_pkg::WINDOW_BITS-1:0] window_ff;
   logic [wpdm_pkg::ENABLE_BITS-1:0] enable_ff;
   logic [wpdm_pkg::DIV_BITS-1:0]    divisor_ff;
   logic [wpdm_pkg::WINDOW_BITS-1:0] window_eff;

   // control
   wpdm_pkg::state_type              state_ff, state_in;
   logic [wpdm_pkg::CH_BITS-1:0]     ch_ff;
   logic                             primed_ff;
   logic                             window_end_ff;
   logic [wpdm_pkg::WINDOW_BITS-1:0] sample_count_ff;
   logic [wpdm_pkg::WINDOW_BITS-1:0] sample_next;
   logic                             rsp_valid_ff;
   logic [wpdm_pkg::CHANNELS*wpdm_pkg::DUTY_BITS-1:0] rsp_data_ff, rsp_data_in;

   // per-request storage
   logic [wpdm_pkg::COUNT_BITS-1:0]  count_ff [wpdm_pkg::CHANNELS];
   logic [wpdm_pkg::DUTY_BITS-1:0]   duty_ff  [wpdm_pkg::CHANNELS];

   // state memory: {last_count, high_ticks} per channel
   logic [wpdm_pkg::ENTRY_BITS-1:0]  mem_ff [wpdm_pkg::CHANNELS];
   logic [wpdm_pkg::CHANNELS-1:0]    entry_valid_ff;
   logic [wpdm_pkg::ENTRY_BITS-1:0]  rd_data_ff;
   logic                             rd_valid_ff;
   logic                             mem_we;
   logic [wpdm_pkg::ENTRY_BITS-1:0]  mem_wdata;

   // read-modify datapath
   logic [wpdm_pkg::ACC_BITS-1:0]    acc_old, acc_sat, acc_new;
   logic [wpdm_pkg::COUNT_BITS-1:0]  last_old, cur_count, inc;
   logic [wpdm_pkg::ACC_BITS:0]      sum;
   logic                             ch_en;
   logic                             last_ch;

   // FSM outputs
   logic                             accept;
   logic                             ch_step;
   logic                             duty_we;
   logic [wpdm_pkg::DUTY_BITS-1:0]   duty_val;
   logic                             rsp_load;

   wpdm_pkg::div_req_type            div_req;
   wpdm_pkg::div_rsp_type            div_rsp;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff  <= wpdm_pkg::TICKS_RESET;
         window_ff <= wpdm_pkg::WINDOW_RESET;
         enable_ff <= wpdm_pkg::ENABLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            wpdm_pkg::CSR_TICKS_PER_SAMPLE:
               ticks_ff <= csr_wdata[wpdm_pkg::TICKS_BITS-1:0];
            wpdm_pkg::CSR_SAMPLES_PER_WINDOW:
               window_ff <= csr_wdata[wpdm_pkg::WINDOW_BITS-1:0];
            wpdm_pkg::CSR_CHANNEL_ENABLE:
               enable_ff <= csr_wdata[wpdm_pkg::ENABLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // window length of zero acts as one
   assign window_eff = (window_ff == '0) ? wpdm_pkg::WINDOW_BITS'(1) : window_ff;

   // full scale, recomputed every cycle; user must keep config stable while busy
   always_ff @(posedge clock) begin
      divisor_ff <= wpdm_pkg::DIV_BITS'(ticks_ff) * wpdm_pkg::DIV_BITS'(window_eff);
   end

   // ---------------- state memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[ch_ff] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[ch_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         rd_valid_ff <= entry_valid_ff[ch_ff];
         if (mem_we) begin
            entry_valid_ff[ch_ff] <= 1'b1;
         end
      end
   end

   // ---------------- read-modify-write ----------------
   always_comb begin
      acc_old   = rd_valid_ff ? rd_data_ff[wpdm_pkg::ACC_BITS-1:0] : '0;
      last_old  = rd_valid_ff ? rd_data_ff[wpdm_pkg::ENTRY_BITS-1:wpdm_pkg::ACC_BITS] : '0;
      cur_count = count_ff[ch_ff];
      inc       = cur_count - last_old;   // wraps modulo 2^16
      sum       = {1'b0, acc_old} + (wpdm_pkg::ACC_BITS + 1)'(inc);
      acc_sat   = sum[wpdm_pkg::ACC_BITS] ? '1 : sum[wpdm_pkg::ACC_BITS-1:0];
      // priming request tracks snapshots only
      ch_en     = primed_ff && enable_ff[ch_ff];
      acc_new   = ch_en ? acc_sat : acc_old;
      mem_wdata = {cur_count, window_end_ff ? wpdm_pkg::ACC_BITS'(0) : acc_new};
   end

   assign last_ch = (ch_ff == wpdm_pkg::CH_BITS'(wpdm_pkg::CHANNELS - 1));

   // count advances by one on counted requests, restarting at zero at window end
   assign sample_next = sample_count_ff + 1'b1;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpdm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      accept           = 1'b0;
      mem_we           = 1'b0;
      ch_step          = 1'b0;
      duty_we          = 1'b0;
      duty_val         = '0;
      rsp_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = acc_new;
      div_req.divisor  = divisor_ff;
      unique case (state_ff)
         wpdm_pkg::ST_IDLE: begin
            accept = req_tvalid;
            if (req_tvalid) begin
               state_in = wpdm_pkg::ST_READ;
            end
         end
         wpdm_pkg::ST_READ: begin
            state_in = wpdm_pkg::ST_MODIFY;
         end
         wpdm_pkg::ST_MODIFY: begin
            mem_we = 1'b1;
            if (window_end_ff && ch_en) begin
               div_req.start = 1'b1;
               state_in      = wpdm_pkg::ST_DIVIDE;
            end else begin
               // disabled channel publishes zero
               duty_we = window_end_ff;
               ch_step = 1'b1;
               if (!last_ch) begin
                  state_in = wpdm_pkg::ST_READ;
               end else if (window_end_ff) begin
                  state_in = wpdm_pkg::ST_PUBLISH;
               end else begin
                  state_in = wpdm_pkg::ST_IDLE;
               end
            end
         end
         wpdm_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               duty_we  = 1'b1;
               duty_val = div_rsp.quotient;
               ch_step  = 1'b1;
               state_in = last_ch ? wpdm_pkg::ST_PUBLISH : wpdm_pkg::ST_READ;
            end
         end
         wpdm_pkg::ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = wpdm_pkg::ST_IDLE;
            end
         end
         default: state_in = wpdm_pkg::ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == wpdm_pkg::ST_IDLE);

   // ---------------- control and payload registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff           <= '0;
         primed_ff       <= 1'b0;
         window_end_ff   <= 1'b0;
         sample_count_ff <= '0;
      end else begin
         if (accept) begin
            ch_ff <= '0;
            if (primed_ff) begin
               // a lowered window ends on the next counted request
               window_end_ff   <= (sample_next >= window_eff);
               sample_count_ff <= (sample_next >= window_eff) ? '0 : sample_next;
            end else begin
               window_end_ff <= 1'b0;
            end
         end else if (ch_step) begin
            ch_ff <= last_ch ? '0 : ch_ff + 1'b1;
            if (last_ch) begin
               primed_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < wpdm_pkg::CHANNELS; i++) begin
            count_ff[i] <= req_tdata[i*wpdm_pkg::COUNT_BITS +: wpdm_pkg::COUNT_BITS];
         end
      end
      if (duty_we) begin
         duty_ff[ch_ff] <= duty_val;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      for (int i = 0; i < wpdm_pkg::CHANNELS; i++) begin
         rsp_data_in[i*wpdm_pkg::DUTY_BITS +: wpdm_pkg::DUTY_BITS] = duty_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- divider ----------------
   wpdm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------- assertions ----------------
   a_publish_only_at_window_end: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == wpdm_pkg::ST_PUBLISH) |-> window_end_ff)
      else $error("publish without window end");

   a_div_done_while_waiting: assert property (
      @(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == wpdm_pkg::ST_DIVIDE))
      else $error("divider finished outside divide state");

   a_result_from_publish: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == wpdm_pkg::ST_PUBLISH))
      else $error("result appeared without publish");

   a_channel_in_range: assert property (
      @(posedge clock) disable iff (reset)
      ch_ff <= wpdm_pkg::CH_BITS'(wpdm_pkg::CHANNELS - 1))
      else $error("channel index out of range");

endmodule

[design/wpdm_divider.sv]
// Serial restoring divider: duty = min(floor(acc * 2^15 / divisor), 1.0), one bit a cycle.
module wpdm_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  wpdm_pkg::div_req_type div_req,
   output wpdm_pkg::div_rsp_type div_rsp
);

   logic                                 busy_ff;
   logic                                 done_ff;
   logic [wpdm_pkg::STEP_BITS-1:0]       step_ff;
   logic [wpdm_pkg::DIV_BITS:0]          rem_ff;
   logic [wpdm_pkg::DIV_BITS-1:0]        div_ff;
   logic [wpdm_pkg::DUTY_BITS-1:0]       quot_ff;

   logic [wpdm_pkg::DIV_BITS:0]          rem_dbl;
   logic                                 fits;

   // remainder stays below the divisor, so doubling needs one extra bit
   assign rem_dbl = {rem_ff[wpdm_pkg::DIV_BITS-1:0], 1'b0};
   assign fits    = rem_dbl >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            if (div_req.divisor == '0) begin
               done_ff <= 1'b1;
               quot_ff <= '0;
            end else if (div_req.dividend >= div_req.divisor) begin
               // ratio at or above one: clamp
               done_ff <= 1'b1;
               quot_ff <= wpdm_pkg::DUTY_ONE;
            end else begin
               busy_ff <= 1'b1;
               step_ff <= wpdm_pkg::STEP_BITS'(wpdm_pkg::FRAC_BITS);
               rem_ff  <= {1'b0, div_req.dividend};
               div_ff  <= div_req.divisor;
               quot_ff <= '0;
            end
         end else if (busy_ff) begin
            rem_ff  <= fits ? (rem_dbl - {1'b0, div_ff}) : rem_dbl;
            quot_ff <= {quot_ff[wpdm_pkg::DUTY_BITS-2:0], fits};
            step_ff <= step_ff - 1'b1;
            if (step_ff == wpdm_pkg::STEP_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule
